>>> design/dtil_pkg.sv
package dtil_pkg;

    // Default table size.
    localparam int TABLE_DEPTH_DEF = 1024;

    // Fixed field widths.
    localparam int CMD_W    = 2;
    localparam int ENTRY_W  = 10;
    localparam int VALUE_W  = 8;
    localparam int HOUR_W   = 32;
    localparam int OFFSET_W = 16;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    // Commands; the fourth code is unused and changes nothing.
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOCATE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HOUR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 2'd2;

    // Configuration reset values.
    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = 11'd1024;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BEFORE_START = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_AFTER_END    = 2'd2;

    // Input word.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ENTRY_W-1:0] entry_index;
        logic [VALUE_W-1:0] entry_value;
        logic [HOUR_W-1:0]  query_hour;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [HOUR_W-1:0]   prev_hour;
        logic [HOUR_W-1:0]   next_hour;
        logic [ENTRY_W-1:0]  position;
        logic                waxing;
        logic [STATUS_W-1:0] status;
    } t_out_word;

endpackage

>>> design/dtil_ram.sv
module dtil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/delta_table_interval_locator.sv
// A load, an unused command or a locate under a held error goes from acceptance through
// EMIT to the result register, a restart through WAIT (the read of entry 0) and EMIT,
// and a locate through DECIDE, then WAIT and DECIDE again for each table step, then EMIT.
// A new word is taken only back in idle; EMIT waits while the result side is stalled.
// Reset clears the sequencer, position, boundaries, status and configuration
// registers; the delta table is not cleared and holds nothing useful until loaded.
module delta_table_interval_locator #(
    parameter int TABLE_DEPTH = dtil_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  dtil_pkg::t_in_word               i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output dtil_pkg::t_out_word              o_out_word,
    input  logic                             i_cfg_we,
    input  logic [dtil_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [dtil_pkg::HOUR_W-1:0]      i_cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CW    = (IDX_W + 1 > dtil_pkg::COUNT_W) ? IDX_W + 1 : dtil_pkg::COUNT_W;
    localparam int PW    = (IDX_W > dtil_pkg::ENTRY_W) ? IDX_W : dtil_pkg::ENTRY_W;

    typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_WAIT, S_EMIT} t_state;
    typedef enum logic [1:0] {OP_RESTART, OP_DOWN, OP_UP} t_op;

    t_state r_state;
    t_op    r_op;

    logic [dtil_pkg::HOUR_W-1:0]   r_base_hour;
    logic [dtil_pkg::OFFSET_W-1:0] r_delta_offset;
    logic [dtil_pkg::COUNT_W-1:0]  r_entry_count;

    logic [IDX_W-1:0]              r_idx;
    logic [dtil_pkg::HOUR_W-1:0]   r_prev;
    logic [dtil_pkg::HOUR_W-1:0]   r_next;
    logic [dtil_pkg::STATUS_W-1:0] r_err;
    logic [dtil_pkg::HOUR_W-1:0]   r_query;
    logic                          r_out_valid;
    dtil_pkg::t_out_word           r_out_word;

    logic                          in_accept;
    logic                          out_free;
    logic [CW-1:0]                 count_ext;
    logic [CW-1:0]                 used;
    logic                          dec_down;
    logic                          dec_up;
    logic                          at_first;
    logic                          at_last;
    logic                          load_ok;
    logic [PW-1:0]                 entry_ext;
    logic [PW-1:0]                 idx_ext;
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [IDX_W-1:0]              ram_raddr;
    logic [dtil_pkg::VALUE_W-1:0]  ram_rdata;
    logic [dtil_pkg::HOUR_W-1:0]   span;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_hour    <= '0;
            r_delta_offset <= '0;
            r_entry_count  <= dtil_pkg::ENTRY_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dtil_pkg::CFG_BASE_HOUR: begin
                    r_base_hour <= i_cfg_wdata;
                end
                dtil_pkg::CFG_DELTA_OFFSET: begin
                    r_delta_offset <= i_cfg_wdata[dtil_pkg::OFFSET_W-1:0];
                end
                dtil_pkg::CFG_ENTRY_COUNT: begin
                    r_entry_count <= i_cfg_wdata[dtil_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Number of entries in use, clamped to one and to the table size.
    assign count_ext = CW'(r_entry_count);
    always_comb begin
        if (count_ext == '0) begin
            used = CW'(1);
        end else if (count_ext > CW'(TABLE_DEPTH)) begin
            used = CW'(TABLE_DEPTH);
        end else begin
            used = count_ext;
        end
    end

    // Walk decisions; stepping down is checked first, as the walk goes down before up.
    assign dec_down = r_prev > r_query;
    assign dec_up   = r_next < r_query;
    assign at_first = r_idx == '0;
    assign at_last  = (CW'(r_idx) + CW'(1)) >= used;

    // Handshakes.
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = r_state != S_IDLE;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Table write on an accepted load; slots beyond the table are dropped.
    assign entry_ext = PW'(i_in_word.entry_index);
    assign load_ok   = CW'(i_in_word.entry_index) < CW'(TABLE_DEPTH);
    assign ram_we    = in_accept && (i_in_word.cmd == dtil_pkg::CMD_LOAD) && load_ok;
    assign ram_waddr = entry_ext[IDX_W-1:0];

    // Read address: entry 0 for a restart, otherwise the neighbour being stepped to.
    always_comb begin
        if (r_state == S_IDLE) begin
            ram_raddr = '0;
        end else if (dec_down) begin
            ram_raddr = r_idx - IDX_W'(1);
        end else begin
            ram_raddr = r_idx + IDX_W'(1);
        end
    end

    dtil_ram #(
        .WIDTH (dtil_pkg::VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_word.entry_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Span of the entry just read.
    assign span = dtil_pkg::HOUR_W'(r_delta_offset) + dtil_pkg::HOUR_W'(ram_rdata);

    assign idx_ext = PW'(r_idx);

    // Sequencer, walk state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_RESTART;
            r_idx       <= '0;
            r_prev      <= '0;
            r_next      <= '0;
            r_err       <= dtil_pkg::STATUS_OK;
            r_query     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_query <= i_in_word.query_hour;
                        case (i_in_word.cmd)
                            dtil_pkg::CMD_RESTART: begin
                                r_idx   <= '0;
                                r_err   <= dtil_pkg::STATUS_OK;
                                r_prev  <= r_base_hour;
                                r_op    <= OP_RESTART;
                                r_state <= S_WAIT;
                            end
                            dtil_pkg::CMD_LOCATE: begin
                                if (r_err == dtil_pkg::STATUS_OK) begin
                                    r_state <= S_DECIDE;
                                end else begin
                                    r_state <= S_EMIT;
                                end
                            end
                            default: begin
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_DECIDE: begin
                    if (dec_down) begin
                        if (at_first) begin
                            r_err   <= dtil_pkg::STATUS_BEFORE_START;
                            r_state <= S_EMIT;
                        end else begin
                            r_idx   <= r_idx - IDX_W'(1);
                            r_op    <= OP_DOWN;
                            r_state <= S_WAIT;
                        end
                    end else if (dec_up) begin
                        if (at_last) begin
                            r_err   <= dtil_pkg::STATUS_AFTER_END;
                            r_state <= S_EMIT;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_op    <= OP_UP;
                            r_state <= S_WAIT;
                        end
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_WAIT: begin
                    case (r_op)
                        OP_DOWN: begin
                            r_next  <= r_prev;
                            r_prev  <= r_prev - span;
                            r_state <= S_DECIDE;
                        end
                        OP_UP: begin
                            r_prev  <= r_next;
                            r_next  <= r_next + span;
                            r_state <= S_DECIDE;
                        end
                        default: begin
                            r_next  <= r_prev + span;
                            r_state <= S_EMIT;
                        end
                    endcase
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid          <= 1'b1;
                        r_out_word.prev_hour <= r_prev;
                        r_out_word.next_hour <= r_next;
                        r_out_word.position  <= idx_ext[dtil_pkg::ENTRY_W-1:0];
                        r_out_word.waxing    <= !r_idx[0];
                        r_out_word.status    <= r_err;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    // An accepted word always starts work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state != S_IDLE)
        else $error("accepted word did not leave idle");

    // Stepping below the first entry raises the status and ends the walk.
    a_before_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && dec_down && at_first)
        |=> (r_err == dtil_pkg::STATUS_BEFORE_START && r_state == S_EMIT))
        else $error("step below first entry not flagged");

    // An upward step moves the old next boundary into prev.
    a_step_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && r_op == OP_UP) |=> r_prev == $past(r_next))
        else $error("upward step lost the next boundary");

    // A free result register is always loaded when a result is ready.
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not delivered to the output register");
`endif

endmodule
